[src/lbs_pkg.sv]
package lbs_pkg;

  localparam int JOINTS = 256;
  localparam int WORDS = 12;
  localparam int FRAC = 16;
  localparam int ROUND_HALF = 1 << (FRAC - 1);
  localparam int MEM_DEPTH = JOINTS * WORDS;
  localparam int MEM_AW = $clog2(MEM_DEPTH);
  localparam int CNT_W = $clog2(WORDS);
  localparam int QAW = 2;
  localparam int QDEPTH = 1 << QAW;

  typedef logic [MEM_AW-1:0] lbs_addr_t;
  typedef logic [CNT_W-1:0] lbs_cnt_t;
  typedef logic [QAW-1:0] lbs_qptr_t;
  typedef logic [QAW:0] lbs_qcnt_t;
  typedef logic [1:0] lbs_kind_t;

  localparam lbs_kind_t KIND_SKIP = 2'd0;
  localparam lbs_kind_t KIND_WRITE = 2'd1;
  localparam lbs_kind_t KIND_INFL = 2'd2;

  localparam lbs_cnt_t CNT_LAST = lbs_cnt_t'(WORDS - 1);
  localparam logic [1:0] COL_X = 2'd0;
  localparam logic [1:0] COL_Y = 2'd1;
  localparam logic [1:0] COL_Z = 2'd2;
  localparam logic [1:0] COL_T = 2'd3;
  localparam logic [1:0] ROW_X = 2'd0;
  localparam logic [1:0] ROW_Y = 2'd1;
  localparam logic [1:0] ROW_Z = 2'd2;

  typedef struct packed {
    lbs_kind_t kind;
    logic zero_mtx;
    logic [7:0] joint;
    logic [3:0] element;
    logic [31:0] value;
    logic [16:0] weight;
    logic [31:0] rest_x;
    logic [31:0] rest_y;
    logic [31:0] rest_z;
    logic last;
  } lbs_entry_t;

endpackage

[src/lbs_front.sv]
module lbs_front (
  input  logic clk,
  input  logic rst_n,
  input  logic in_push,
  output logic in_full,
  input  logic in_opcode,
  input  logic [7:0] in_joint,
  input  logic [3:0] in_element,
  input  logic signed [31:0] in_value,
  input  logic [16:0] in_weight,
  input  logic signed [31:0] in_rest_x,
  input  logic signed [31:0] in_rest_y,
  input  logic signed [31:0] in_rest_z,
  input  logic in_last,
  output logic q_valid,
  output lbs_pkg::lbs_entry_t q_head,
  input  logic q_pop
);

  lbs_pkg::lbs_entry_t fifo_r [lbs_pkg::QDEPTH];
  lbs_pkg::lbs_qptr_t wp_r;
  lbs_pkg::lbs_qptr_t rp_r;
  lbs_pkg::lbs_qcnt_t cnt_r;
  lbs_pkg::lbs_qcnt_t cnt_nxt;
  lbs_pkg::lbs_entry_t entry;
  logic in_range;
  logic push_ok;

  assign in_full = (cnt_r == lbs_pkg::lbs_qcnt_t'(lbs_pkg::QDEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_head = fifo_r[rp_r];
  assign push_ok = in_push && !in_full;
  assign in_range = int'(in_joint) < lbs_pkg::JOINTS;

  always_comb begin
    entry.kind = lbs_pkg::KIND_SKIP;
    if (in_opcode) begin
      entry.kind = lbs_pkg::KIND_INFL;
    end else if (in_range && (int'(in_element) < lbs_pkg::WORDS)) begin
      entry.kind = lbs_pkg::KIND_WRITE;
    end
    entry.zero_mtx = !in_range;
    entry.joint = in_joint;
    entry.element = in_element;
    entry.value = in_value;
    entry.weight = in_weight;
    entry.rest_x = in_rest_x;
    entry.rest_y = in_rest_y;
    entry.rest_z = in_rest_z;
    entry.last = in_last;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (push_ok && !q_pop) begin
      cnt_nxt = cnt_r + lbs_pkg::lbs_qcnt_t'(1);
    end else if (!push_ok && q_pop) begin
      cnt_nxt = cnt_r - lbs_pkg::lbs_qcnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push_ok) begin
        wp_r <= wp_r + lbs_pkg::lbs_qptr_t'(1);
      end
      if (q_pop) begin
        rp_r <= rp_r + lbs_pkg::lbs_qptr_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      fifo_r[wp_r] <= entry;
    end
  end

`ifndef ASSERT_OFF
  // The engine must never take a transaction from an empty queue.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> cnt_r != '0)
    else $error("queue popped while empty");
`endif

endmodule

[src/lbs_back.sv]
module lbs_back (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  input  lbs_pkg::lbs_entry_t q_head,
  output logic q_pop,
  output logic out_empty,
  input  logic out_pop,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic out_overflow
);

  function automatic logic [32:0] sat32(input logic signed [63:0] v);
    logic [32:0] res;
    if (v > 64'sd2147483647) begin
      res = {1'b1, 32'h7FFF_FFFF};
    end else if (v < -64'sd2147483648) begin
      res = {1'b1, 32'h8000_0000};
    end else begin
      res = {1'b0, v[31:0]};
    end
    return res;
  endfunction

  logic signed [31:0] mtx_mem_r [lbs_pkg::MEM_DEPTH];
  lbs_pkg::lbs_addr_t wr_addr;
  lbs_pkg::lbs_addr_t rd_addr;
  lbs_pkg::lbs_addr_t base_r;
  logic signed [31:0] rdata_r;

  logic issuing_r;
  lbs_pkg::lbs_cnt_t cnt_r;
  logic va_r, vb_r, vt_r, vd_r, ve_r, vf_r;
  lbs_pkg::lbs_cnt_t idx_a_r;
  lbs_pkg::lbs_cnt_t idx_b_r;
  logic [1:0] row_t_r, row_d_r, row_e_r;

  logic [16:0] w_r;
  logic signed [31:0] rest_x_r, rest_y_r, rest_z_r;
  logic last_r;
  logic zero_r;

  logic signed [31:0] mdata;
  logic signed [31:0] opb;
  logic signed [63:0] prod_nxt;
  logic signed [63:0] prod_r;
  logic signed [65:0] sum_r;
  logic signed [65:0] sum_nxt;
  logic signed [49:0] t_r;
  logic [41:0] pl_r;
  logic signed [42:0] ph_r;
  logic signed [67:0] wt;
  logic signed [51:0] c_r;

  logic signed [63:0] acc_x_r, acc_y_r, acc_z_r;
  logic signed [63:0] acc_sel;
  logic signed [64:0] acc_sum;
  logic signed [63:0] acc_nxt;

  logic out_valid_r;
  logic signed [31:0] pos_x_r, pos_y_r, pos_z_r;
  logic ovf_r;
  logic [32:0] sx, sy, sz;

  logic idle;
  logic start;
  logic start_infl;
  logic wr_en;
  logic load_out;

  assign idle = !(issuing_r || va_r || vb_r || vt_r || vd_r || ve_r || vf_r);
  assign start = q_valid && idle &&
                 ((q_head.kind != lbs_pkg::KIND_INFL) || !q_head.last || !out_valid_r);
  assign q_pop = start;
  assign start_infl = start && (q_head.kind == lbs_pkg::KIND_INFL);
  assign wr_en = start && (q_head.kind == lbs_pkg::KIND_WRITE);
  assign load_out = vf_r && last_r;

  assign wr_addr = lbs_pkg::lbs_addr_t'(q_head.joint) *
                   lbs_pkg::lbs_addr_t'(lbs_pkg::WORDS) +
                   lbs_pkg::lbs_addr_t'(q_head.element);
  assign rd_addr = base_r + lbs_pkg::lbs_addr_t'(cnt_r);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mtx_mem_r[wr_addr] <= q_head.value;
    end
    if (issuing_r) begin
      rdata_r <= mtx_mem_r[rd_addr];
    end
  end

  assign mdata = zero_r ? 32'sd0 : rdata_r;

  always_comb begin
    case (idx_a_r[1:0])
      lbs_pkg::COL_X: opb = rest_x_r;
      lbs_pkg::COL_Y: opb = rest_y_r;
      lbs_pkg::COL_Z: opb = rest_z_r;
      default: opb = 32'sd1 <<< lbs_pkg::FRAC;
    endcase
  end

  assign prod_nxt = mdata * opb;
  assign sum_nxt = ((idx_b_r[1:0] == lbs_pkg::COL_X) ? 66'(lbs_pkg::ROUND_HALF) : sum_r) +
                   66'(prod_r);
  assign wt = (68'(ph_r) <<< 25) + 68'(pl_r) + 68'(lbs_pkg::ROUND_HALF);

  always_comb begin
    case (row_e_r)
      lbs_pkg::ROW_X: acc_sel = acc_x_r;
      lbs_pkg::ROW_Y: acc_sel = acc_y_r;
      default: acc_sel = acc_z_r;
    endcase
    acc_sum = 65'(acc_sel) + 65'(c_r);
    if (acc_sum[64] != acc_sum[63]) begin
      acc_nxt = acc_sum[64] ? -64'sh7FFF_FFFF_FFFF_FFFF - 64'sd1 : 64'sh7FFF_FFFF_FFFF_FFFF;
    end else begin
      acc_nxt = acc_sum[63:0];
    end
  end

  assign sx = sat32(acc_x_r);
  assign sy = sat32(acc_y_r);
  assign sz = sat32(acc_z_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issuing_r <= 1'b0;
      cnt_r <= '0;
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vt_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
      vf_r <= 1'b0;
      out_valid_r <= 1'b0;
      acc_x_r <= '0;
      acc_y_r <= '0;
      acc_z_r <= '0;
    end else begin
      if (start_infl) begin
        issuing_r <= 1'b1;
        cnt_r <= '0;
      end else if (issuing_r) begin
        cnt_r <= cnt_r + lbs_pkg::lbs_cnt_t'(1);
        if (cnt_r == lbs_pkg::CNT_LAST) begin
          issuing_r <= 1'b0;
        end
      end
      va_r <= issuing_r;
      vb_r <= va_r;
      vt_r <= vb_r && (idx_b_r[1:0] == lbs_pkg::COL_T);
      vd_r <= vt_r;
      ve_r <= vd_r;
      vf_r <= ve_r && (row_e_r == lbs_pkg::ROW_Z);
      if (ve_r) begin
        case (row_e_r)
          lbs_pkg::ROW_X: acc_x_r <= acc_nxt;
          lbs_pkg::ROW_Y: acc_y_r <= acc_nxt;
          default: acc_z_r <= acc_nxt;
        endcase
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
        acc_x_r <= '0;
        acc_y_r <= '0;
        acc_z_r <= '0;
      end else if (out_pop && out_valid_r) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_infl) begin
      base_r <= lbs_pkg::lbs_addr_t'(q_head.joint) * lbs_pkg::lbs_addr_t'(lbs_pkg::WORDS);
      w_r <= q_head.weight;
      rest_x_r <= q_head.rest_x;
      rest_y_r <= q_head.rest_y;
      rest_z_r <= q_head.rest_z;
      last_r <= q_head.last;
      zero_r <= q_head.zero_mtx;
    end
    idx_a_r <= cnt_r;
    prod_r <= prod_nxt;
    idx_b_r <= idx_a_r;
    if (vb_r) begin
      sum_r <= sum_nxt;
      t_r <= sum_nxt[65:16];
      row_t_r <= idx_b_r[3:2];
    end
    pl_r <= w_r * t_r[24:0];
    ph_r <= $signed({1'b0, w_r}) * $signed(t_r[49:25]);
    row_d_r <= row_t_r;
    c_r <= wt[67:16];
    row_e_r <= row_d_r;
    if (load_out) begin
      pos_x_r <= sx[31:0];
      pos_y_r <= sy[31:0];
      pos_z_r <= sz[31:0];
      ovf_r <= sx[32] | sy[32] | sz[32];
    end
  end

  assign out_empty = !out_valid_r;
  assign out_pos_x = pos_x_r;
  assign out_pos_y = pos_y_r;
  assign out_pos_z = pos_z_r;
  assign out_overflow = ovf_r;

`ifndef ASSERT_OFF
  // A finished vertex must find the result register free.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> !out_valid_r)
    else $error("result register overwritten");
  // Each influence reads exactly one full matrix.
  a_issue_len: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(issuing_r) |-> $past(cnt_r) == lbs_pkg::CNT_LAST)
    else $error("matrix read sequence has wrong length");
  // After the final stage nothing of the influence is left in flight.
  a_drained: assert property (@(posedge clk) disable iff (!rst_n)
    vf_r |=> !(issuing_r || va_r || vb_r || vt_r || vd_r || ve_r || vf_r))
    else $error("pipeline not drained after vertex");
`endif

endmodule

[src/linear_blend_skinning.sv]
// Channel  Direction  Handshake          Payload
// in_      input      in_push / in_full   opcode, joint, element, value, weight, rest_*, last
// out_     output     out_pop / out_empty pos_x, pos_y, pos_z, overflow
//
// A matrix word write goes straight to the matrix store in the engine. For an influence, twelve
// matrix words are read one per cycle through a single memory port, and then the multiply,
// rounding and accumulate stages drain before the engine takes the next transaction.
// A pushed transaction is registered in the queue before the engine takes it; up to four wait there.
// Reset is synchronous and clears the queue, the engine and the accumulators; the matrix
// store holds no defined value until written.
// A last influence waits in the queue until the result register is empty.
module linear_blend_skinning (
  input  logic clk,
  input  logic rst_n,
  input  logic in_push,
  output logic in_full,
  input  logic in_opcode,
  input  logic [7:0] in_joint,
  input  logic [3:0] in_element,
  input  logic signed [31:0] in_value,
  input  logic [16:0] in_weight,
  input  logic signed [31:0] in_rest_x,
  input  logic signed [31:0] in_rest_y,
  input  logic signed [31:0] in_rest_z,
  input  logic in_last,
  output logic out_empty,
  input  logic out_pop,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic out_overflow
);

  logic q_valid;
  logic q_pop;
  lbs_pkg::lbs_entry_t q_head;

  lbs_front u_front (
    .clk(clk),
    .rst_n(rst_n),
    .in_push(in_push),
    .in_full(in_full),
    .in_opcode(in_opcode),
    .in_joint(in_joint),
    .in_element(in_element),
    .in_value(in_value),
    .in_weight(in_weight),
    .in_rest_x(in_rest_x),
    .in_rest_y(in_rest_y),
    .in_rest_z(in_rest_z),
    .in_last(in_last),
    .q_valid(q_valid),
    .q_head(q_head),
    .q_pop(q_pop)
  );

  lbs_back u_back (
    .clk(clk),
    .rst_n(rst_n),
    .q_valid(q_valid),
    .q_head(q_head),
    .q_pop(q_pop),
    .out_empty(out_empty),
    .out_pop(out_pop),
    .out_pos_x(out_pos_x),
    .out_pos_y(out_pos_y),
    .out_pos_z(out_pos_z),
    .out_overflow(out_overflow)
  );

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps

module tb;

  localparam bit OP_WRITE = 1'b0;
  localparam bit OP_INFLUENCE = 1'b1;
  localparam int IDLE_LIMIT = 4000;
  localparam int ITEM_GOAL = 450;

  typedef logic signed [69:0] wide_t;

  localparam wide_t ACC_MAX = (wide_t'(1) <<< 63) - 1;
  localparam wide_t ACC_MIN = -(wide_t'(1) <<< 63);
  localparam longint POS_MAX = 64'sd2147483647;
  localparam longint POS_MIN = -64'sd2147483648;

  typedef struct packed {
    bit opcode;
    bit [7:0] joint;
    bit [3:0] element;
    bit [31:0] value;
    bit [16:0] weight;
    bit [31:0] rest_x;
    bit [31:0] rest_y;
    bit [31:0] rest_z;
    bit last;
    bit known;
    bit [31:0] known_x;
    bit [31:0] known_y;
    bit [31:0] known_z;
    bit known_ovf;
  } skin_item_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic ovf;
  } vertex_pos_t;

  logic clk;
  logic rst_n;
  logic in_push;
  logic in_full;
  logic in_opcode;
  logic [7:0] in_joint;
  logic [3:0] in_element;
  logic signed [31:0] in_value;
  logic [16:0] in_weight;
  logic signed [31:0] in_rest_x;
  logic signed [31:0] in_rest_y;
  logic signed [31:0] in_rest_z;
  logic in_last;
  logic out_empty;
  logic out_pop;
  logic signed [31:0] out_pos_x;
  logic signed [31:0] out_pos_y;
  logic signed [31:0] out_pos_z;
  logic out_overflow;

  logic [31:0] mtx_words [lbs_pkg::JOINTS*lbs_pkg::WORDS];
  longint acc_sum [3];
  vertex_pos_t pos_expected [$];
  vertex_pos_t seen_want;
  bit [lbs_pkg::WORDS-1:0] word_set [lbs_pkg::JOINTS];
  bit joint_ready [lbs_pkg::JOINTS];
  logic [7:0] usable [$];
  skin_item_t directed_rows [$];
  int items_sent = 0;
  int fail_count = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;

  wire in_take = in_push && !in_full;
  wire out_take = out_pop && !out_empty;

  linear_blend_skinning DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_push(in_push),
    .in_full(in_full),
    .in_opcode(in_opcode),
    .in_joint(in_joint),
    .in_element(in_element),
    .in_value(in_value),
    .in_weight(in_weight),
    .in_rest_x(in_rest_x),
    .in_rest_y(in_rest_y),
    .in_rest_z(in_rest_z),
    .in_last(in_last),
    .out_empty(out_empty),
    .out_pop(out_pop),
    .out_pos_x(out_pos_x),
    .out_pos_y(out_pos_y),
    .out_pos_z(out_pos_z),
    .out_overflow(out_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic wide_t sx32(logic [31:0] v);
    return {{38{v[31]}}, v};
  endfunction

  function automatic wide_t joint_row(logic [7:0] jt, int row, logic [31:0] rx,
                                      logic [31:0] ry, logic [31:0] rz);
    wide_t m [4];
    wide_t sum;
    int k;
    for (k = 0; k < 4; k++) begin
      m[k] = (int'(jt) < lbs_pkg::JOINTS) ?
             sx32(mtx_words[int'(jt)*lbs_pkg::WORDS + row*4 + k]) : '0;
    end
    sum = m[0] * sx32(rx) + m[1] * sx32(ry) + m[2] * sx32(rz) + wide_t'(lbs_pkg::ROUND_HALF);
    return (sum >>> lbs_pkg::FRAC) + m[3];
  endfunction

  function automatic wide_t weighted(logic [16:0] w, wide_t t);
    wide_t wv;
    wv = {53'b0, w};
    return (wv * t + wide_t'(lbs_pkg::ROUND_HALF)) >>> lbs_pkg::FRAC;
  endfunction

  function automatic longint add_sat64(longint a, wide_t c);
    wide_t s;
    s = wide_t'(a) + c;
    if (s > ACC_MAX) return longint'(ACC_MAX);
    if (s < ACC_MIN) return longint'(ACC_MIN);
    return longint'(s);
  endfunction

  function automatic logic [32:0] clamp32(longint v);
    if (v > POS_MAX) return {1'b1, 32'h7FFF_FFFF};
    if (v < POS_MIN) return {1'b1, 32'h8000_0000};
    return {1'b0, v[31:0]};
  endfunction

  function automatic void skin_predict(skin_item_t it);
    logic [32:0] cx;
    logic [32:0] cy;
    logic [32:0] cz;
    vertex_pos_t want;
    int row;
    if (it.opcode == OP_WRITE) begin
      if (int'(it.joint) < lbs_pkg::JOINTS && it.element < lbs_pkg::WORDS) begin
        mtx_words[int'(it.joint)*lbs_pkg::WORDS + int'(it.element)] = it.value;
      end
      return;
    end
    for (row = 0; row < 3; row++) begin
      acc_sum[row] = add_sat64(acc_sum[row],
        weighted(it.weight, joint_row(it.joint, row, it.rest_x, it.rest_y, it.rest_z)));
    end
    if (!it.last) return;
    cx = clamp32(acc_sum[0]);
    cy = clamp32(acc_sum[1]);
    cz = clamp32(acc_sum[2]);
    if (it.known) begin
      want = '{it.known_x, it.known_y, it.known_z, it.known_ovf};
    end else begin
      want = '{cx[31:0], cy[31:0], cz[31:0], cx[32] | cy[32] | cz[32]};
    end
    pos_expected.push_back(want);
    for (row = 0; row < 3; row++) acc_sum[row] = 0;
  endfunction

  function automatic skin_item_t mk_write(logic [7:0] jt, logic [3:0] el, logic [31:0] val,
                                          bit lst);
    skin_item_t it;
    it = '0;
    it.opcode = OP_WRITE;
    it.joint = jt;
    it.element = el;
    it.value = val;
    it.last = lst;
    return it;
  endfunction

  function automatic skin_item_t mk_infl(logic [7:0] jt, logic [16:0] w, logic [31:0] rx,
                                         logic [31:0] ry, logic [31:0] rz, bit lst);
    skin_item_t it;
    it = '0;
    it.opcode = OP_INFLUENCE;
    it.joint = jt;
    it.weight = w;
    it.rest_x = rx;
    it.rest_y = ry;
    it.rest_z = rz;
    it.last = lst;
    return it;
  endfunction

  function automatic skin_item_t mk_known(skin_item_t it, logic [31:0] ex, logic [31:0] ey,
                                          logic [31:0] ez, bit eovf);
    it.known = 1'b1;
    it.known_x = ex;
    it.known_y = ey;
    it.known_z = ez;
    it.known_ovf = eovf;
    return it;
  endfunction

  function automatic logic [31:0] rand_mtx_word(int el);
    if ($urandom_range(0, 9) == 0) return $urandom;
    if (el % 4 == 3) return int'($urandom_range(0, 1 << 29)) - (1 << 28);
    return int'($urandom_range(0, 1 << 18)) - (1 << 17);
  endfunction

  function automatic logic [31:0] rand_rest();
    if ($urandom_range(0, 99) < 15) return $urandom;
    return int'($urandom_range(0, 1 << 27)) - (1 << 26);
  endfunction

  function automatic logic [16:0] rand_weight();
    if ($urandom_range(0, 99) < 15) return 17'($urandom_range(0, 131071));
    return 17'($urandom_range(0, 65536));
  endfunction

  function automatic int idle_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic drive_item(input skin_item_t it);
    int gap;
    gap = idle_gap();
    repeat (gap) begin
      @(negedge clk);
      in_push <= 1'b0;
    end
    @(negedge clk);
    in_push <= 1'b1;
    in_opcode <= it.opcode;
    in_joint <= it.joint;
    in_element <= it.element;
    in_value <= it.value;
    in_weight <= it.weight;
    in_rest_x <= it.rest_x;
    in_rest_y <= it.rest_y;
    in_rest_z <= it.rest_z;
    in_last <= it.last;
    @(posedge clk);
    while (in_full) @(posedge clk);
    skin_predict(it);
    if (it.opcode == OP_WRITE && it.element < lbs_pkg::WORDS) begin
      word_set[it.joint][it.element] = 1'b1;
      if (&word_set[it.joint] && !joint_ready[it.joint]) begin
        joint_ready[it.joint] = 1'b1;
        usable.push_back(it.joint);
      end
    end
    if (!(it.opcode == OP_WRITE && it.element >= lbs_pkg::WORDS)) items_sent++;
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    in_push <= 1'b0;
    while (pos_expected.size() != 0) @(posedge clk);
  endtask

  initial begin
    int r;
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      r = $urandom_range(0, 99);
      if (r < 8 && !calm) begin
        out_pop <= 1'b0;
        repeat ($urandom_range(8, 40)) @(negedge clk);
      end else begin
        out_pop <= (r < 70) || calm;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (pos_expected.size() == 0) begin
        $error("unexpected transaction: pos_x %0d pos_y %0d pos_z %0d overflow %0d",
               out_pos_x, out_pos_y, out_pos_z, out_overflow);
        fail_count++;
      end else begin
        seen_want = pos_expected.pop_front();
        if (out_pos_x !== seen_want.x) begin
          $error("pos_x: expected %0d, got %0d", $signed(seen_want.x), out_pos_x);
          fail_count++;
        end
        if (out_pos_y !== seen_want.y) begin
          $error("pos_y: expected %0d, got %0d", $signed(seen_want.y), out_pos_y);
          fail_count++;
        end
        if (out_pos_z !== seen_want.z) begin
          $error("pos_z: expected %0d, got %0d", $signed(seen_want.z), out_pos_z);
          fail_count++;
        end
        if (out_overflow !== seen_want.ovf) begin
          $error("overflow: expected %0d, got %0d", seen_want.ovf, out_overflow);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || in_take || out_take) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("FAIL linear_blend_skinning");
    $finish;
  end

  initial begin
    int r;
    int n;
    int k;
    int e;
    logic [7:0] jt;
    skin_item_t it;

    rst_n = 1'b0;
    in_push = 1'b0;
    in_opcode = OP_WRITE;
    in_joint = '0;
    in_element = '0;
    in_value = '0;
    in_weight = '0;
    in_rest_x = '0;
    in_rest_y = '0;
    in_rest_z = '0;
    in_last = 1'b0;
    for (k = 0; k < 3; k++) acc_sum[k] = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (e = 0; e < lbs_pkg::WORDS; e++) begin
      drive_item(mk_write(8'd0, 4'(e), (e % 5 == 0) ? 32'h0001_0000 : 32'h0, 1'b0));
      drive_item(mk_write(8'd255, 4'(e), 32'h7FFF_FFFF, 1'b0));
      drive_item(mk_write(8'd128, 4'(e), 32'h8000_0000, 1'b0));
      drive_item(mk_write(8'd2, 4'(e), rand_mtx_word(e), 1'b0));
    end

    directed_rows.push_back(mk_known(mk_infl(8'd0, 17'd0, 32'h0, 32'h0, 32'h0, 1'b1),
                                     32'h0, 32'h0, 32'h0, 1'b0));
    directed_rows.push_back(mk_known(mk_infl(8'd0, 17'd65536, 32'h1_0000, 32'h2_0000,
                                             -32'sh3_0000, 1'b1),
                                     32'h1_0000, 32'h2_0000, -32'sh3_0000, 1'b0));
    directed_rows.push_back(mk_write(8'd0, 4'd12, 32'hDEAD_BEEF, 1'b1));
    directed_rows.push_back(mk_write(8'd0, 4'd15, 32'h1234_5678, 1'b0));
    directed_rows.push_back(mk_known(mk_infl(8'd0, 17'd65536, 32'h7FFF_FFFF, 32'h8000_0000,
                                             32'h0, 1'b1),
                                     32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b0));
    directed_rows.push_back(mk_known(mk_infl(8'd0, 17'd131071, 32'h1_0000, 32'h0, 32'h0, 1'b1),
                                     32'd131071, 32'h0, 32'h0, 1'b0));
    directed_rows.push_back(mk_infl(8'd255, 17'd131071, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                    32'h7FFF_FFFF, 1'b0));
    directed_rows.push_back(mk_known(mk_infl(8'd255, 17'd131071, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                             32'h7FFF_FFFF, 1'b1),
                                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1));
    directed_rows.push_back(mk_known(mk_infl(8'd128, 17'd65536, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                             32'h7FFF_FFFF, 1'b1),
                                     32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1));
    directed_rows.push_back(mk_known(mk_infl(8'd128, 17'd65536, 32'h8000_0000, 32'h8000_0000,
                                             32'h8000_0000, 1'b1),
                                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1));
    directed_rows.push_back(mk_infl(8'd0, 17'd1, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1));
    directed_rows.push_back(mk_infl(8'd2, 17'd32768, 32'h0003_8000, 32'hFFF0_0000,
                                    32'h0000_4000, 1'b0));
    directed_rows.push_back(mk_write(8'd2, 4'd3, 32'h0064_0000, 1'b1));
    directed_rows.push_back(mk_infl(8'd2, 17'd32768, 32'h0003_8000, 32'hFFF0_0000,
                                    32'h0000_4000, 1'b0));
    directed_rows.push_back(mk_infl(8'd0, 17'd65536, 32'h0001_2345, 32'hFFFE_0001,
                                    32'h0000_0007, 1'b1));
    directed_rows.push_back(mk_write(8'd2, 4'd0, 32'h8000_0000, 1'b0));
    directed_rows.push_back(mk_infl(8'd2, 17'd65536, 32'h0001_0000, 32'h0001_0000,
                                    32'h0001_0000, 1'b1));
    directed_rows.push_back(mk_infl(8'd0, 17'd65536, 32'h1_0000, 32'h0, 32'h0, 1'b0));
    directed_rows.push_back(mk_known(mk_infl(8'd0, 17'd65536, -32'sh1_0000, 32'h0, 32'h0,
                                             1'b1),
                                     32'h0, 32'h0, 32'h0, 1'b0));
    directed_rows.push_back(mk_known(mk_infl(8'd255, 17'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                             32'h7FFF_FFFF, 1'b1),
                                     32'h0, 32'h0, 32'h0, 1'b0));

    foreach (directed_rows[k]) drive_item(directed_rows[k]);
    hold_until_drained();

    while (items_sent < ITEM_GOAL) begin
      calm = ($urandom_range(0, 7) == 0);
      r = $urandom_range(0, 99);
      if (r < 15) begin
        jt = 8'($urandom_range(0, 255));
        for (e = 0; e < lbs_pkg::WORDS; e++) begin
          drive_item(mk_write(jt, 4'(e), rand_mtx_word(e), 1'($urandom)));
        end
      end else if (r < 25) begin
        n = $urandom_range(1, 3);
        for (k = 0; k < n; k++) begin
          drive_item(mk_write(8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)), $urandom,
                              1'($urandom)));
        end
      end else begin
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
        if ($urandom_range(0, 19) == 0) n = 1;
        for (k = 0; k < n; k++) begin
          if (k != 0 && $urandom_range(0, 9) == 0) begin
            jt = usable[$urandom_range(0, usable.size() - 1)];
            drive_item(mk_write(jt, 4'($urandom_range(0, lbs_pkg::WORDS - 1)),
                                rand_mtx_word(k), 1'b0));
          end
          jt = usable[$urandom_range(0, usable.size() - 1)];
          it = mk_infl(jt, rand_weight(), rand_rest(), rand_rest(), rand_rest(), k == n - 1);
          if (n == 1 && $urandom_range(0, 3) == 0) it.weight = '0;
          drive_item(it);
        end
        if ($urandom_range(0, 99) == 0) hold_until_drained();
      end
    end
    calm = 1'b0;

    hold_until_drained();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS linear_blend_skinning");
    end else begin
      $display("FAIL linear_blend_skinning");
    end
    $finish;
  end

endmodule
